// File: design/ckpc_pkg.sv
// ============================================================================
// ckpc_pkg
// Shared types, constants and helper functions of the canonical k-mer
// profile counter.
// ============================================================================
package ckpc_pkg;

   localparam int MAX_K      = 6;
   localparam int COUNT_BITS = 24;

   localparam int CODE_W      = 2 * MAX_K;
   localparam int TABLE_DEPTH = 1 << CODE_W;
   localparam int CFG_K_W     = 3;
   localparam int KEFF_W      = $clog2(MAX_K + 1);
   localparam int CHAR_W      = 8;
   localparam int KCOUNT_W    = 24;
   localparam int LEN_W       = 24;
   localparam int PROF_W      = 29;
   localparam int WEIGHT_W    = 2;
   localparam int KIND_W      = 2;
   localparam int SHIFT_W     = $clog2(2 * MAX_K + 17);
   localparam int NUM_W       = COUNT_BITS + 2 * MAX_K + 16;
   localparam int STEP_W      = $clog2(NUM_W + 1);

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEN_W-1:0]      LEN_MAX   = {LEN_W{1'b1}};
   localparam logic [PROF_W-1:0]     PROF_MAX  = {PROF_W{1'b1}};

   // register index of kmer_length
   localparam logic [CSR_ADDR_W-3:0] REG_KMER_LENGTH = '0;
   localparam logic [CFG_K_W-1:0]    KMER_LENGTH_RESET = 3'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_BASE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [WEIGHT_W-1:0] {
      WEIGHT_NONE = 2'd0,
      WEIGHT_HALF = 2'd1,
      WEIGHT_FULL = 2'd2
   } weight_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BASE_WR,
      ST_READ_DATA,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] count;
      logic [SHIFT_W-1:0]    shift;
      logic [LEN_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROF_W-1:0] quotient;
   } div_res_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] digit;
   } base_code_type;

   // clamp the raw k register to 1..MAX_K
   function automatic logic [KEFF_W-1:0] eff_k(logic [CFG_K_W-1:0] raw);
      logic [KEFF_W:0] wide;
      wide = (KEFF_W + 1)'(raw);
      if (raw == '0) begin
         return KEFF_W'(1);
      end else if (wide > (KEFF_W + 1)'(MAX_K)) begin
         return KEFF_W'(MAX_K);
      end else begin
         return KEFF_W'(raw);
      end
   endfunction

   function automatic logic [CODE_W-1:0] kmer_mask(logic [KEFF_W-1:0] k);
      return ~({CODE_W{1'b1}} << (2 * int'(k)));
   endfunction

   function automatic base_code_type base_code(logic [CHAR_W-1:0] c);
      base_code_type res;
      res.ok    = 1'b1;
      res.digit = 2'd0;
      unique case (c)
         8'h41, 8'h61: res.digit = 2'd0; // A a
         8'h43, 8'h63: res.digit = 2'd1; // C c
         8'h54, 8'h74: res.digit = 2'd2; // T t
         8'h47, 8'h67: res.digit = 2'd3; // G g
         default: res.ok = 1'b0;
      endcase
      return res;
   endfunction

   // reverse complement of a k-digit code: digit i moves to k-1-i, xor 2
   function automatic logic [CODE_W-1:0] rev_comp(logic [CODE_W-1:0] code,
                                                  logic [KEFF_W-1:0] k);
      logic [CODE_W-1:0] r;
      r = '0;
      for (int i = 0; i < MAX_K; i++) begin
         if (i < int'(k)) begin
            r[2 * (int'(k) - 1 - i) +: 2] = code[2 * i +: 2] ^ 2'b10;
         end
      end
      return r;
   endfunction

endpackage

// File: design/canonical_kmer_profile_counter.sv
// ============================================================================
// canonical_kmer_profile_counter
// Canonical k-mer counter over a 4^MAX_K count table with profile readout.
// ============================================================================
// Usage:
//   req_* channel takes one item per handshake; req_tuser is the item kind.
//   A base item shifts one character into the forward and reverse-complement
//   windows and bumps the count of the smaller code once k bases are in.
//   A read item returns the entry's count, weight class, profile value and
//   the current sequence length on rsp_*. A clear item zeroes table, windows
//   and length and answers with clear_done set in rsp_tuser. The user is to
//   write kmer_length over the csr_* port while the block is idle (unchecked by the block).
// Item flow:
//   base item: table read at accept, write back next cycle.
//   read item: table read at accept; unless the profile is known to be zero,
//     the bit-serial divider (one quotient bit per cycle over 52 bits) forms it.
//   clear item: clearing pass over all 4096 table entries, then the result.
// Reset runs the same clearing pass; req_tready stays low during it, csr writes
// are taken. Results sit in an output register; a stalled receiver holds that
// register and the block stops only once a second result is ready to go out.
// ============================================================================
module canonical_kmer_profile_counter (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: base_char[7:0], entry_index[19:8], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ckpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: kind[1:0]
   input  logic [ckpc_pkg::KIND_W-1:0]         req_tuser,
   // rsp_tdata: kmer_count[23:0], weight_class[25:24], profile_value[54:26],
   //            sequence_length[78:55], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ckpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: clear_done[0]
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ckpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ckpc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ckpc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // ---------------------------------------------------------------- fields
   logic [ckpc_pkg::CHAR_W-1:0]   base_char;
   logic [ckpc_pkg::CODE_W-1:0]   entry_index;
   ckpc_pkg::kind_type            kind;

   assign base_char   = req_tdata[7:0];
   assign entry_index = req_tdata[19:8];
   assign kind        = ckpc_pkg::kind_type'(req_tuser);

   // ---------------------------------------------------------------- state
   ckpc_pkg::state_type               state_ff, state_in;
   logic [ckpc_pkg::CFG_K_W-1:0]      k_raw_ff, k_raw_in;
   logic [ckpc_pkg::CODE_W-1:0]       fw_ff, fw_in;
   logic [ckpc_pkg::CODE_W-1:0]       rv_ff, rv_in;
   logic [ckpc_pkg::LEN_W-1:0]        total_ff, total_in;
   logic [ckpc_pkg::CODE_W-1:0]       clr_ptr_ff, clr_ptr_in;
   logic                              clr_resp_ff, clr_resp_in;
   logic                              count_en_ff, count_en_in;
   logic [ckpc_pkg::CODE_W-1:0]       canon_ff, canon_in;
   ckpc_pkg::weight_type              cls_ff, cls_in;
   logic                              oor_ff, oor_in;
   logic [ckpc_pkg::SHIFT_W-1:0]      shift_ff, shift_in;
   logic [ckpc_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [ckpc_pkg::PROF_W-1:0]       prof_ff, prof_in;
   logic                              done_flag_ff, done_flag_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ckpc_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              rsp_user_ff, rsp_user_in;

   // ---------------------------------------------------------------- datapath wires
   logic                              accept;
   logic                              push;
   logic                              clear_last;
   logic                              need_div;
   logic [ckpc_pkg::KEFF_W-1:0]       k_eff;
   logic [ckpc_pkg::CODE_W-1:0]       mask;
   ckpc_pkg::base_code_type           bc;
   logic [1:0]                        rdigit;
   logic [ckpc_pkg::CODE_W-1:0]       fw_next;
   logic [ckpc_pkg::CODE_W-1:0]       rv_next;
   logic [ckpc_pkg::LEN_W-1:0]        total_next;
   logic [ckpc_pkg::CODE_W-1:0]       canon_next;
   logic [ckpc_pkg::CODE_W-1:0]       rc_index;
   ckpc_pkg::weight_type              cls_next;

   logic                              ram_wr_en;
   logic [ckpc_pkg::CODE_W-1:0]       ram_wr_addr;
   logic [ckpc_pkg::COUNT_BITS-1:0]   ram_wr_data;
   logic                              ram_rd_en;
   logic [ckpc_pkg::CODE_W-1:0]       ram_rd_addr;
   logic [ckpc_pkg::COUNT_BITS-1:0]   ram_rd_data;

   ckpc_pkg::div_req_type             div_req;
   ckpc_pkg::div_res_type             div_res;

   logic                              csr_write;

   // ---------------------------------------------------------------- units
   ckpc_ram #(
      .WIDTH (ckpc_pkg::COUNT_BITS),
      .DEPTH (ckpc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ckpc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   // ---------------------------------------------------------------- window and code logic
   always_comb begin
      k_eff      = ckpc_pkg::eff_k(k_raw_ff);
      mask       = ckpc_pkg::kmer_mask(k_eff);
      bc         = ckpc_pkg::base_code(base_char);
      // unknown characters code as 0 in both windows, no complement
      rdigit     = bc.ok ? (bc.digit ^ 2'b10) : 2'b00;
      fw_next    = ((fw_ff << 2) | ckpc_pkg::CODE_W'(bc.digit)) & mask;
      rv_next    = (((rv_ff & mask) >> 2)
                    | (ckpc_pkg::CODE_W'(rdigit) << (2 * (int'(k_eff) - 1)))) & mask;
      total_next = (total_ff == ckpc_pkg::LEN_MAX) ? total_ff : total_ff + 1'b1;
      canon_next = (fw_next < rv_next) ? fw_next : rv_next;
      rc_index   = ckpc_pkg::rev_comp(entry_index, k_eff);
      if (rc_index == entry_index) begin
         cls_next = ckpc_pkg::WEIGHT_FULL;
      end else if (rc_index > entry_index) begin
         cls_next = ckpc_pkg::WEIGHT_HALF;
      end else begin
         cls_next = ckpc_pkg::WEIGHT_NONE;
      end
   end

   assign accept     = req_tvalid & req_tready;
   assign push       = (state_ff == ckpc_pkg::ST_PUSH) & (~rsp_valid_ff | rsp_tready);
   assign clear_last = clr_ptr_ff == ckpc_pkg::CODE_W'(ckpc_pkg::TABLE_DEPTH - 1);
   assign need_div   = ~oor_ff & (cls_ff != ckpc_pkg::WEIGHT_NONE)
                       & (total_ff != '0) & (ram_rd_data != '0);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ckpc_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = clr_resp_ff ? ckpc_pkg::ST_PUSH : ckpc_pkg::ST_IDLE;
            end
         end
         ckpc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  ckpc_pkg::KIND_BASE:  state_in = ckpc_pkg::ST_BASE_WR;
                  ckpc_pkg::KIND_READ:  state_in = ckpc_pkg::ST_READ_DATA;
                  ckpc_pkg::KIND_CLEAR: state_in = ckpc_pkg::ST_CLEAR;
                  ckpc_pkg::KIND_NONE:  state_in = ckpc_pkg::ST_IDLE;
               endcase
            end
         end
         ckpc_pkg::ST_BASE_WR: state_in = ckpc_pkg::ST_IDLE;
         ckpc_pkg::ST_READ_DATA: begin
            state_in = need_div ? ckpc_pkg::ST_DIVIDE : ckpc_pkg::ST_PUSH;
         end
         ckpc_pkg::ST_DIVIDE: begin
            if (div_res.done) begin
               state_in = ckpc_pkg::ST_PUSH;
            end
         end
         ckpc_pkg::ST_PUSH: begin
            if (push) begin
               state_in = ckpc_pkg::ST_IDLE;
            end
         end
         default: state_in = ckpc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control outputs
   always_comb begin
      req_tready      = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = canon_ff;
      ram_wr_data     = ram_rd_data + 1'b1;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = canon_next;
      div_req.start   = 1'b0;
      div_req.count   = ram_rd_data;
      div_req.shift   = shift_ff;
      div_req.divisor = total_ff;
      unique case (state_ff)
         ckpc_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ptr_ff;
            ram_wr_data = '0;
         end
         ckpc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            ram_rd_en   = 1'b1;
            // base: read the canonical entry now; read item: the asked entry
            ram_rd_addr = (kind == ckpc_pkg::KIND_READ) ? entry_index : canon_next;
         end
         ckpc_pkg::ST_BASE_WR: begin
            // hold saturated counts
            ram_wr_en = count_en_ff & (ram_rd_data != ckpc_pkg::COUNT_MAX);
         end
         ckpc_pkg::ST_READ_DATA: begin
            div_req.start = need_div;
         end
         ckpc_pkg::ST_DIVIDE,
         ckpc_pkg::ST_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- register updates
   always_comb begin
      csr_write    = csr_psel & csr_penable & csr_pwrite & csr_pready;
      k_raw_in     = k_raw_ff;
      fw_in        = fw_ff;
      rv_in        = rv_ff;
      total_in     = total_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_resp_in  = clr_resp_ff;
      count_en_in  = count_en_ff;
      canon_in     = canon_ff;
      cls_in       = cls_ff;
      oor_in       = oor_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      prof_in      = prof_ff;
      done_flag_in = done_flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_write && csr_paddr[ckpc_pkg::CSR_ADDR_W-1:2] == ckpc_pkg::REG_KMER_LENGTH) begin
         k_raw_in = csr_pwdata[ckpc_pkg::CFG_K_W-1:0];
      end

      if (state_ff == ckpc_pkg::ST_CLEAR) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
      end

      if (accept) begin
         unique case (kind)
            ckpc_pkg::KIND_BASE: begin
               fw_in       = fw_next;
               rv_in       = rv_next;
               total_in    = total_next;
               canon_in    = canon_next;
               count_en_in = total_next >= ckpc_pkg::LEN_W'(k_eff);
            end
            ckpc_pkg::KIND_READ: begin
               cls_in       = cls_next;
               oor_in       = entry_index > mask;
               shift_in     = ckpc_pkg::SHIFT_W'(2 * int'(k_eff))
                              + ((cls_next == ckpc_pkg::WEIGHT_FULL)
                                 ? ckpc_pkg::SHIFT_W'(16) : ckpc_pkg::SHIFT_W'(15));
               prof_in      = '0;
               done_flag_in = 1'b0;
            end
            ckpc_pkg::KIND_CLEAR: begin
               fw_in        = '0;
               rv_in        = '0;
               total_in     = '0;
               clr_ptr_in   = '0;
               clr_resp_in  = 1'b1;
               count_in     = '0;
               cls_in       = ckpc_pkg::WEIGHT_NONE;
               prof_in      = '0;
               done_flag_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ckpc_pkg::ST_READ_DATA) begin
         // out-of-range entries answer zero count, weight class and profile
         count_in = oor_ff ? '0 : ram_rd_data;
         if (oor_ff) begin
            cls_in = ckpc_pkg::WEIGHT_NONE;
         end
      end

      if (state_ff == ckpc_pkg::ST_DIVIDE && div_res.done) begin
         prof_in = div_res.quotient;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0,
                         total_ff,
                         prof_ff,
                         ckpc_pkg::WEIGHT_W'(cls_ff),
                         ckpc_pkg::KCOUNT_W'(count_ff)};
         rsp_user_in  = done_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ckpc_pkg::ST_CLEAR;
         k_raw_ff     <= ckpc_pkg::KMER_LENGTH_RESET;
         fw_ff        <= '0;
         rv_ff        <= '0;
         total_ff     <= '0;
         clr_ptr_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         count_en_ff  <= 1'b0;
         done_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_raw_ff     <= k_raw_in;
         fw_ff        <= fw_in;
         rv_ff        <= rv_in;
         total_ff     <= total_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_resp_ff  <= clr_resp_in;
         count_en_ff  <= count_en_in;
         done_flag_ff <= done_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      canon_ff    <= canon_in;
      cls_ff      <= cls_in;
      oor_ff      <= oor_in;
      shift_ff    <= shift_in;
      count_ff    <= count_in;
      prof_ff     <= prof_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // ---------------------------------------------------------------- ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ckpc_pkg::CSR_ADDR_W-1:2] == ckpc_pkg::REG_KMER_LENGTH)
                       ? ckpc_pkg::CSR_DATA_W'(k_raw_ff) : '0;

endmodule

// File: design/ckpc_ram.sv
// ============================================================================
// ckpc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ============================================================================
module ckpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ckpc_div.sv
// ============================================================================
// ckpc_div
// Bit-serial restoring divider: (count << shift) / divisor, one quotient bit
// per cycle, result saturated to the profile width.
// ============================================================================
module ckpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ckpc_pkg::div_req_type req,
   output ckpc_pkg::div_res_type res
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           sat_ff, sat_in;
   logic [ckpc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ckpc_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [ckpc_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [ckpc_pkg::LEN_W-1:0]     divisor_ff, divisor_in;
   logic [ckpc_pkg::PROF_W-1:0]    quo_ff, quo_in;
   logic [ckpc_pkg::LEN_W:0]       trial;
   logic [ckpc_pkg::LEN_W:0]       diff;
   logic                           ge;

   always_comb begin
      trial = {rem_ff, num_ff[ckpc_pkg::NUM_W-1]};
      diff  = trial - (ckpc_pkg::LEN_W + 1)'(divisor_ff);
      ge    = trial >= (ckpc_pkg::LEN_W + 1)'(divisor_ff);

      busy_in    = busy_ff;
      done_in    = 1'b0;
      sat_in     = sat_ff;
      step_in    = step_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;

      if (req.start) begin
         busy_in    = 1'b1;
         sat_in     = 1'b0;
         step_in    = '0;
         num_in     = ckpc_pkg::NUM_W'(req.count) << req.shift;
         rem_in     = '0;
         divisor_in = req.divisor;
         quo_in     = '0;
      end else if (busy_ff) begin
         // shift-subtract; a one leaving the top of the quotient means overflow
         num_in  = num_ff << 1;
         rem_in  = ge ? ckpc_pkg::LEN_W'(diff) : ckpc_pkg::LEN_W'(trial);
         quo_in  = {quo_ff[ckpc_pkg::PROF_W-2:0], ge};
         sat_in  = sat_ff | quo_ff[ckpc_pkg::PROF_W-1];
         step_in = step_ff + 1'b1;
         if (step_ff == ckpc_pkg::STEP_W'(ckpc_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      sat_ff     <= sat_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = sat_ff ? ckpc_pkg::PROF_MAX : quo_ff;

endmodule

// File: design/ckpc_checker.sv
// ============================================================================
// ckpc_checker
// Port-level checks of the canonical k-mer profile counter.
// ============================================================================
module ckpc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [ckpc_pkg::KIND_W-1:0]        req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ckpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                               rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // base item blocks the next cycle for the table write-back
   a_base_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ckpc_pkg::KIND_BASE |=> !req_tready)
      else $error("item accepted during table write-back");

   // clear acknowledge carries all-zero data
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("clear result with nonzero data");

   // unreported entries have zero profile; class code 3 never appears
   a_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:24] != 2'd3
                     && (rsp_tdata[25:24] != 2'd0 || rsp_tdata[54:26] == '0))
      else $error("bad weight class or profile");

endmodule

bind canonical_kmer_profile_counter ckpc_checker u_ckpc_checker (.*);

// File: sim/canonical_kmer_profile_counter_tb.sv
// ============================================================================
// canonical_kmer_profile_counter_tb
// Self-checking bench for the canonical k-mer profile counter. A tally board
// mirrors the count table, the two rolling windows and the length. It works
// out every read and clear answer as the item is accepted, then compares the
// answers that come back on rsp_* field by field. Stimulus opens with
// directed items at the reset k and then runs random phases at several k
// settings, with both handshake sides idling at random.
// ============================================================================
module canonical_kmer_profile_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ckpc_pkg::*;

   // Give up after this many cycles without any item moving on either side.
   // The slowest legal gap is a clearing pass over the table plus a stalled sink.
   localparam int STALL_LIMIT = 20000;

   // kmer_length is register 0, so it sits at byte address 0
   localparam logic [CSR_ADDR_W-1:0] KMER_LENGTH_ADDR = {REG_KMER_LENGTH, 2'b00};

   // One expected answer on the result channel
   typedef struct {
      logic [KCOUNT_W-1:0] count;
      weight_type          weight;
      logic [PROF_W-1:0]   profile;
      logic [LEN_W-1:0]    length;
      logic                clear_done;
   } kmer_readout_type;

   // -------------------------------------------------------------------------
   // Tally board: own copy of the counter state plus the answers still due
   // -------------------------------------------------------------------------
   class kmer_tally_board_type;
      int unsigned        tally[TABLE_DEPTH];
      int unsigned        fwd_code;
      int unsigned        rc_code;
      int unsigned        bases_total;
      logic [CFG_K_W-1:0] k_reg;
      kmer_readout_type   readouts_due[$];
      int unsigned        n_base, n_read, n_clear, n_ignored, n_checked, n_errors;

      function new();
         wipe_tally();
         k_reg = KMER_LENGTH_RESET;
      endfunction

      function void wipe_tally();
         foreach (tally[i]) tally[i] = 0;
         fwd_code    = 0;
         rc_code     = 0;
         bases_total = 0;
      endfunction

      function int unsigned pending();
         return readouts_due.size();
      endfunction

      // a register value of 0 behaves as 1, anything above MAX_K as MAX_K
      function int unsigned active_k();
         if (k_reg == 0) return 1;
         if (k_reg > MAX_K) return MAX_K;
         return k_reg;
      endfunction

      function bit char_digit(logic [CHAR_W-1:0] ch, output int unsigned d);
         case (ch)
            "A", "a": d = 0;
            "C", "c": d = 1;
            "T", "t": d = 2;
            "G", "g": d = 3;
            default: begin
               d = 0;
               return 1'b0;
            end
         endcase
         return 1'b1;
      endfunction

      function int unsigned revcomp_of(int unsigned code, int unsigned k);
         int unsigned r;
         r = 0;
         for (int i = 0; i < k; i++) r = (r << 2) | (((code >> (2 * i)) & 3) ^ 2);
         return r;
      endfunction

      // count * weight * 4^k / length with 16 fraction bits, saturating
      function logic [PROF_W-1:0] profile_of(int unsigned cnt, weight_type cls,
                                             int unsigned k);
         int unsigned     sh;
         longint unsigned whole, rem, frac, v;
         if (cls == WEIGHT_NONE || bases_total == 0) return '0;
         sh    = 2 * k + ((cls == WEIGHT_FULL) ? 16 : 15);
         whole = cnt / bases_total;
         rem   = cnt % bases_total;
         frac  = (rem << sh) / bases_total;
         if (whole != 0 && (sh >= PROF_W || whole > (PROF_MAX >> sh))) return PROF_MAX;
         v = (whole << sh) + frac;
         return (v > PROF_MAX) ? PROF_MAX : v[PROF_W-1:0];
      endfunction

      function void shift_base(logic [CHAR_W-1:0] ch);
         int unsigned d, rd, k, mask, canon;
         bit          ok;
         k    = active_k();
         mask = (1 << (2 * k)) - 1;
         ok   = char_digit(ch, d);
         // non-base characters enter both windows as 0, uncomplemented
         rd   = ok ? (d ^ 2) : 0;
         fwd_code = ((fwd_code << 2) | d) & mask;
         rc_code  = (((rc_code & mask) >> 2) | (rd << (2 * (k - 1)))) & mask;
         if (bases_total < LEN_MAX) bases_total++;
         if (bases_total >= k) begin
            canon = (fwd_code < rc_code) ? fwd_code : rc_code;
            canon &= TABLE_DEPTH - 1;
            if (tally[canon] < COUNT_MAX) tally[canon]++;
         end
      endfunction

      function kmer_readout_type read_entry(logic [CODE_W-1:0] idx);
         kmer_readout_type ro;
         int unsigned      k, rc, cnt;
         weight_type       cls;
         k             = active_k();
         ro.count      = '0;
         ro.weight     = WEIGHT_NONE;
         ro.profile    = '0;
         ro.length     = bases_total[LEN_W-1:0];
         ro.clear_done = 1'b0;
         // indexes of 4^k and above answer all zero apart from the length
         if (idx <= (1 << (2 * k)) - 1) begin
            rc  = revcomp_of(idx, k);
            cnt = tally[idx];
            if (rc == idx) cls = WEIGHT_FULL;
            else if (rc > idx) cls = WEIGHT_HALF;
            else cls = WEIGHT_NONE;
            ro.count   = cnt[KCOUNT_W-1:0];
            ro.weight  = cls;
            ro.profile = profile_of(cnt, cls, k);
         end
         return ro;
      endfunction

      // Note an item accepted by the block
      function void take_item(kind_type kind, logic [CHAR_W-1:0] ch,
                              logic [CODE_W-1:0] idx);
         kmer_readout_type ro;
         case (kind)
            KIND_BASE: begin
               n_base++;
               shift_base(ch);
            end
            KIND_READ: begin
               n_read++;
               readouts_due.push_back(read_entry(idx));
            end
            KIND_CLEAR: begin
               n_clear++;
               wipe_tally();
               ro.count      = '0;
               ro.weight     = WEIGHT_NONE;
               ro.profile    = '0;
               ro.length     = '0;
               ro.clear_done = 1'b1;
               readouts_due.push_back(ro);
            end
            default: n_ignored++;
         endcase
      endfunction

      function void field_check(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            n_errors++;
         end
      endfunction

      // Compare one accepted result with the oldest answer due
      function void match_readout(logic [RSP_DATA_W-1:0] data, logic done);
         kmer_readout_type want;
         n_checked++;
         if (readouts_due.size() == 0) begin
            $display("%0t: result with nothing expected, tdata %h tuser %b",
                     $time, data, done);
            n_errors++;
            return;
         end
         want = readouts_due.pop_front();
         field_check("kmer_count", want.count, data[23:0]);
         field_check("weight_class", want.weight, data[25:24]);
         field_check("profile_value", want.profile, data[54:26]);
         field_check("sequence_length", want.length, data[78:55]);
         field_check("clear_done", want.clear_done, done);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals: every block input starts at a known value
   // -------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // req_tdata: base_char[7:0], entry_index[19:8], zero fill
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // req_tuser: kind[1:0]
   logic [KIND_W-1:0]     req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // rsp_tdata: kmer_count[23:0], weight_class[25:24], profile_value[54:26],
   //            sequence_length[78:55], zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // rsp_tuser: clear_done[0]
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   kmer_tally_board_type sb = new();

   logic [CHAR_W-1:0] letters[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

   bit src_burst;          // sender offers items back to back while set
   bit sink_burst;         // receiver takes results without stalls while set
   int rsp_hold_cycles;    // one-off long hold-off requested of the receiver
   int n_k_writes;
   int quiet_cycles;

   canonical_kmer_profile_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Taps: note accepted items and check accepted results. Both sample the
   // values from before the edge, since every driver uses nonblocking writes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.take_item(kind_type'(req_tuser), req_tdata[7:0], req_tdata[19:8]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.match_readout(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: count cycles in which no item moves on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results still due",
                  $time, STALL_LIMIT, sb.pending());
         $display("canonical_kmer_profile_counter: mismatch");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: draw a stall per result, or take a requested long hold-off.
   // Keep tready high across back-to-back results instead of re-raising it.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      wait (!reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 17);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Offer one item after a random gap; return at the edge that takes it.
   // Leave tvalid high so a following item without a gap goes out at once.
   task automatic send_item(kind_type kind, logic [CHAR_W-1:0] ch,
                            logic [CODE_W-1:0] idx, bit eager = 1'b0);
      int gap;
      if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
      gap = (eager || src_burst) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, idx, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and hold until every answer is in. Then allow for a base
   // item still in its write-back cycle, since it gives no result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the
   // edge that ends the access cycle
   task automatic write_kmer_length(logic [CFG_K_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= KMER_LENGTH_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.k_reg = value;
      n_k_writes++;
   endtask

   // One random phase at a fixed k. Bases mostly follow a short repeating
   // motif so that some entries build up real counts. Reads aim at the
   // latest k-mer or its reverse complement, at any valid code, or at the
   // whole index range. Clears and unknown kinds are rare.
   task automatic random_phase(logic [CFG_K_W-1:0] k_raw, bit wipe_first, int n_items);
      logic [CHAR_W-1:0] motif[6];
      logic [CHAR_W-1:0] ch;
      logic [CODE_W-1:0] idx;
      int                motif_len, motif_pos, sent, pick;
      int unsigned       k, mask, recent, d;
      drain_results();
      write_kmer_length(k_raw);
      k         = sb.active_k();
      mask      = (1 << (2 * k)) - 1;
      motif_len = $urandom_range(1, 6);
      foreach (motif[j]) motif[j] = letters[$urandom_range(0, 7)];
      motif_pos = 0;
      recent    = 0;
      sent      = 0;
      if (wipe_first) begin
         send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                   CODE_W'($urandom_range(0, 4095)));
      end
      while (sent < n_items) begin
         pick = $urandom_range(0, 199);
         ch   = CHAR_W'($urandom_range(0, 255));
         idx  = CODE_W'($urandom_range(0, 4095));
         if (pick < 4) begin
            // unknown kind: the block drops it, so it does not count
            send_item(KIND_NONE, ch, idx);
         end else begin
            sent++;
            if (pick == 4) begin
               send_item(KIND_CLEAR, ch, idx);
            end else if (pick < 35) begin
               case ($urandom_range(0, 4))
                  0: idx = CODE_W'(recent);
                  1: idx = CODE_W'(sb.revcomp_of(recent, k));
                  2, 3: idx = CODE_W'($urandom_range(0, mask));
                  default: ;
               endcase
               send_item(KIND_READ, ch, idx);
            end else begin
               if ($urandom_range(0, 9) < 7) begin
                  ch = motif[motif_pos];
                  motif_pos = (motif_pos + 1) % motif_len;
               end else if ($urandom_range(0, 2) != 0) begin
                  ch = letters[$urandom_range(0, 7)];
               end
               void'(sb.char_digit(ch, d));
               recent = ((recent << 2) | d) & mask;
               send_item(KIND_BASE, ch, idx);
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset k of 5. Read an empty table with length 0.
      send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), 12'd0);
      // every letter in both cases
      foreach (letters[j]) send_item(KIND_BASE, letters[j], CODE_W'($urandom_range(0, 4095)));
      // five non-base characters in a row: code 0 fills both windows
      send_item(KIND_BASE, "N", 12'hFFF);
      send_item(KIND_BASE, 8'h00, 12'h000);
      send_item(KIND_BASE, 8'hFF, 12'hFFF);
      send_item(KIND_BASE, "-", 12'h000);
      send_item(KIND_BASE, 8'h80, 12'hFFF);
      // unknown kind with all data bits set: no result
      send_item(KIND_NONE, 8'hFF, 12'hFFF);
      // code 0, the top valid code, and both ends of the out-of-range span
      send_item(KIND_READ, 8'hFF, 12'd0);
      send_item(KIND_READ, 8'h00, 12'd1023);
      send_item(KIND_READ, 8'hFF, 12'd1024);
      send_item(KIND_READ, 8'h00, 12'd4095);
      // clear, then read back the emptied entry
      send_item(KIND_CLEAR, 8'hFF, 12'hFFF);
      send_item(KIND_READ, 8'h00, 12'd0);

      // Random phases: walk k over its range, the out-of-range values too.
      // Some phases keep the old windows to cover a k change mid-stream.
      random_phase(3'd1, 1'b1, 110);
      random_phase(3'd6, 1'b0, 110);
      random_phase(3'd2, 1'b1, 110);

      // Back-pressure: hold off the receiver for a long stretch while
      // reads go in back to back, so the block fills and stalls its input
      drain_results();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2) begin
            send_item(KIND_BASE, letters[$urandom_range(0, 7)], 12'd0, 1'b1);
         end else begin
            send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                      CODE_W'($urandom_range(0, 15)), 1'b1);
         end
      end

      random_phase(3'd0, 1'b0, 90);
      random_phase(3'd7, 1'b1, 110);
      random_phase(3'd3, 1'b0, 90);
      random_phase(3'd4, 1'b1, 110);
      random_phase(3'd6, 1'b1, 110);
      random_phase(3'd5, 1'b0, 90);
      random_phase(3'd1, 1'b0, 80);

      // Let the last answers arrive, then watch for strays
      drain_results();
      repeat (64) @(posedge clock);

      $display("run covered %0d base, %0d read, %0d clear and %0d dropped items",
               sb.n_base, sb.n_read, sb.n_clear, sb.n_ignored);
      $display("%0d results checked over %0d k settings, 0 through 7 among them",
               sb.n_checked, n_k_writes);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("canonical_kmer_profile_counter: match");
      end else begin
         $display("canonical_kmer_profile_counter: mismatch");
      end
      $finish;
   end

endmodule
